### hw/rtl/psfn_pkg.sv
// shared types and constants for the pcm sample format normalizer
// no dependencies; used by the config registers, the datapath and the top level
package psfn_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDE_SAMPLES       = 3'd0,
		REG_STEREO_INTERLEAVED = 3'd1,
		REG_BIG_ENDIAN_WORDS   = 3'd2,
		REG_DELTA_CODED        = 3'd3,
		REG_UNSIGNED_CODED     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic wide_samples;
		logic stereo_interleaved;
		logic big_endian_words;
		logic delta_coded;
		logic unsigned_coded;
	} cfg_t;

	localparam logic [15:0] SIGN_WIDE   = 16'h8000;
	localparam logic [15:0] SIGN_NARROW = 16'h0080;
	localparam logic [15:0] MASK_WIDE   = 16'hFFFF;
	localparam logic [15:0] MASK_NARROW = 16'h00FF;

endpackage

### hw/rtl/psfn_cfg_regs.sv
// configuration register bank of the pcm sample format normalizer
// depends on psfn_pkg for the register indexes and the cfg_t struct
module psfn_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [psfn_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic                          wr_data,
	output psfn_pkg::cfg_t                cfg
);

	psfn_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				psfn_pkg::REG_WIDE_SAMPLES:       cfg_q.wide_samples       <= wr_data;
				psfn_pkg::REG_STEREO_INTERLEAVED: cfg_q.stereo_interleaved <= wr_data;
				psfn_pkg::REG_BIG_ENDIAN_WORDS:   cfg_q.big_endian_words   <= wr_data;
				psfn_pkg::REG_DELTA_CODED:        cfg_q.delta_coded        <= wr_data;
				psfn_pkg::REG_UNSIGNED_CODED:     cfg_q.unsigned_coded     <= wr_data;
				// indexes past the list are dropped
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/psfn_datapath.sv
// conversion stage: byte swap, delta accumulate, sign flip and extend
// holds the per-channel sums, the channel toggle and the result register
// depends on psfn_pkg
module psfn_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  psfn_pkg::cfg_t cfg,
	input  logic           load,
	input  logic [15:0]    word_s1,
	input  logic           start_s1,
	output logic [15:0]    result_s2,
	output logic           right_s2
);

	logic [15:0] left_sum_q;
	logic [15:0] right_sum_q;
	logic        toggle_q;

	logic [15:0] mask;
	logic [15:0] sign;
	logic [15:0] v;
	logic [15:0] lsum_eff;
	logic [15:0] rsum_eff;
	logic        right;
	logic [15:0] sum;
	logic [15:0] val;
	logic [15:0] val_ext;

	always_comb begin
		mask = cfg.wide_samples ? psfn_pkg::MASK_WIDE : psfn_pkg::MASK_NARROW;
		sign = cfg.wide_samples ? psfn_pkg::SIGN_WIDE : psfn_pkg::SIGN_NARROW;

		if (cfg.wide_samples && cfg.big_endian_words)
			v = {word_s1[7:0], word_s1[15:8]};
		else
			v = word_s1;
		v = v & mask;

		// start of a sample clears both sums and returns to left
		lsum_eff = start_s1 ? 16'h0000 : left_sum_q;
		rsum_eff = start_s1 ? 16'h0000 : right_sum_q;
		right    = cfg.stereo_interleaved & ~start_s1 & toggle_q;

		sum = ((right ? rsum_eff : lsum_eff) + v) & mask;

		priority if (cfg.delta_coded)
			val = sum;
		else if (cfg.unsigned_coded)
			val = v ^ sign;
		else
			val = v;
		val = val & mask;

		val_ext = cfg.wide_samples ? val : {{8{val[7]}}, val[7:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q  <= '0;
			right_sum_q <= '0;
			toggle_q    <= 1'b0;
		end else if (load) begin
			left_sum_q  <= (cfg.delta_coded && !right) ? sum : lsum_eff;
			right_sum_q <= (cfg.delta_coded && right) ? sum : rsum_eff;
			toggle_q    <= cfg.stereo_interleaved & ~right;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= val_ext;
			right_s2  <= right;
		end
	end

endmodule

### hw/rtl/pcm_sample_format_normalizer.sv
// top level of the pcm sample format normalizer: handshake, input register
// depends on psfn_pkg, psfn_cfg_regs and psfn_datapath
//
// One stored word in, one signed 16-bit sample out, one word per cycle
// sustained while the output does not stall. A word is held in the input
// register and then converted into the result register, which presents it
// as the result; the running delta sums are updated by a single 16-bit add
// in that conversion step, which also updates the channel toggle. The input
// side keeps accepting while a result waits, and only stalls when the input
// register and the result register are both full and the output is stalled.
// Configuration writes are always ready and take effect from the next
// converted word.
module pcm_sample_format_normalizer (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psfn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                           cfg_data,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    raw_word,
	input  logic                           sample_start,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             linear_sample,
	output logic                           right_channel
);

	psfn_pkg::cfg_t cfg;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        start_s1;
	logic        valid_s2;
	logic        adv_s2;
	logic        load_s2;
	logic        take_in;
	logic [15:0] result_s2;
	logic        right_s2;

	assign cfg_ready = 1'b1;

	psfn_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv_s2   = ~valid_s2 | ~out_stall;
	assign load_s2  = valid_s1 & adv_s2;
	assign in_stall = valid_s1 & ~adv_s2;
	assign take_in  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;
			if (load_s2)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1  <= raw_word;
			start_s1 <= sample_start;
		end
	end

	psfn_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.load      (load_s2),
		.word_s1   (word_s1),
		.start_s1  (start_s1),
		.result_s2 (result_s2),
		.right_s2  (right_s2)
	);

	assign out_valid     = valid_s2;
	assign linear_sample = result_s2;
	assign right_channel = right_s2;

	// input only backs up when both registers hold a word
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free register");

	// a word moved into the result register shows up as a result
	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> out_valid)
		else $error("converted word lost");

	// a result blocked downstream keeps the input register from being overwritten
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> (valid_s1 && $stable(word_s1) && $stable(start_s1)))
		else $error("pending input word overwritten");

endmodule
